>>> design/fpdm_pkg.sv
// Package for the frequency/period/duty meter: beat payload structs,
// operation and mode codes, fixed field widths. No dependencies.
`default_nettype none

package fpdm_pkg;

  localparam int unsigned TS_W   = 48;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned GATE_W = 16;

  localparam logic [GATE_W-1:0] GATE_RESET = 16'd1000;

  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_TICK = 2'd1,
    OP_ARM  = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_COUNT  = 2'd1,
    MODE_PERIOD = 2'd2,
    MODE_DUTY   = 2'd3
  } mode_e;

  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_THIRD  = 2'd2;

  typedef struct packed {
    logic [1:0]      operation;
    logic [TS_W-1:0] timestamp;
    logic [1:0]      arm_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       mode_now;
    logic             done_res;
    logic [CNT_W-1:0] edges_counted;
    logic [TS_W-1:0]  period_time;
    logic [TS_W-1:0]  high_time;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/frequency_period_duty_meter.sv
// Top level of the frequency/period/duty meter: handshake, gate length
// register, two-entry result buffer. Depends on fpdm_pkg and fpdm_core.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  in_data_i  (in_item_t)
//   out      source     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg      sink       cfg_we_i                cfg_wdata_i (gate length)
//
// One beat per cycle unless in_stall_o is high; each input beat yields one result beat.
// State updates in the cycle a beat is taken; the result sits in an output
// register backed by a skid register, so input is stalled only when both hold.
// Reset clears the measurement state and sets the gate length to 1000.
`default_nettype none

module frequency_period_duty_meter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire fpdm_pkg::in_item_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output fpdm_pkg::out_item_t               out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [fpdm_pkg::GATE_W-1:0]  cfg_wdata_i
);
  import fpdm_pkg::*;

  logic [GATE_W-1:0] gate_len_q;
  logic              in_accept;
  logic              out_pop;
  out_item_t         result;
  out_item_t         out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_pop     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_len_q <= GATE_RESET;
    end else if (cfg_we_i) begin
      gate_len_q <= cfg_wdata_i;
    end
  end

  fpdm_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .item_i        (in_data_i),
    .gate_length_i (gate_len_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_pop) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid beat without output beat");
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && !skid_valid_q && in_valid_i |=> skid_valid_q)
    else $error("stalled beat not parked in skid");
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_stall_i |=> !skid_valid_q && out_valid_q)
    else $error("skid beat not moved to output");
`endif

endmodule

`default_nettype wire

>>> design/fpdm_core.sv
// Measurement state and next-state logic for the meter: one beat per cycle when accept_i is high.
// Depends on fpdm_pkg.
`default_nettype none

module fpdm_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire fpdm_pkg::in_item_t       item_i,
  input  wire logic [fpdm_pkg::GATE_W-1:0] gate_length_i,
  output fpdm_pkg::out_item_t           result_o
);
  import fpdm_pkg::*;

  mode_e             mode_q, mode_d;
  logic [1:0]        idx_q, idx_d;
  logic [TS_W-1:0]   first_q, first_d;
  logic [CNT_W-1:0]  edges_q, edges_d;
  logic [GATE_W-1:0] gate_q, gate_d;
  logic [TS_W-1:0]   period_q, period_d;
  logic [TS_W-1:0]   high_q, high_d;
  logic              done;

  logic [TS_W-1:0]   ts;
  logic [TS_W-1:0]   elapsed;
  logic [GATE_W-1:0] gate_inc;

  assign ts       = item_i.timestamp;
  assign elapsed  = ts - first_q;
  assign gate_inc = gate_q + GATE_W'(1);

  always_comb begin
    mode_d   = mode_q;
    idx_d    = idx_q;
    first_d  = first_q;
    edges_d  = edges_q;
    gate_d   = gate_q;
    period_d = period_q;
    high_d   = high_q;
    done     = 1'b0;
    unique case (op_e'(item_i.operation))
      OP_EDGE: begin
        unique case (mode_q)
          MODE_COUNT: edges_d = edges_q + CNT_W'(1);
          MODE_PERIOD: begin
            if (idx_q == IDX_FIRST) begin
              first_d = ts;
              idx_d   = IDX_SECOND;
            end else begin
              period_d = elapsed;
              mode_d   = MODE_IDLE;
              idx_d    = IDX_FIRST;
              done     = 1'b1;
            end
          end
          MODE_DUTY: begin
            if (idx_q == IDX_FIRST) begin
              first_d = ts;
              idx_d   = IDX_SECOND;
            end else if (idx_q == IDX_SECOND) begin
              high_d = elapsed;
              idx_d  = IDX_THIRD;
            end else begin
              period_d = elapsed;
              mode_d   = MODE_IDLE;
              idx_d    = IDX_FIRST;
              done     = 1'b1;
            end
          end
          default: idx_d = IDX_FIRST;
        endcase
      end
      OP_TICK: begin
        if (mode_q == MODE_COUNT) begin
          gate_d = gate_inc;
          if (gate_inc >= gate_length_i) begin
            mode_d = MODE_IDLE;
            gate_d = '0;
            done   = 1'b1;
          end
        end
      end
      OP_ARM: begin
        mode_d  = mode_e'(item_i.arm_mode);
        idx_d   = IDX_FIRST;
        edges_d = '0;
        gate_d  = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.mode_now      = mode_d;
    result_o.done_res      = done;
    result_o.edges_counted = edges_d;
    result_o.period_time   = period_d;
    result_o.high_time     = high_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      idx_q    <= IDX_FIRST;
      first_q  <= '0;
      edges_q  <= '0;
      gate_q   <= '0;
      period_q <= '0;
      high_q   <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      idx_q    <= idx_d;
      first_q  <= first_d;
      edges_q  <= edges_d;
      gate_q   <= gate_d;
      period_q <= period_d;
      high_q   <= high_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3) else $error("capture index out of range");
  a_idx_third_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q == IDX_THIRD |-> mode_q == MODE_DUTY) else $error("third edge outside duty mode");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && done |-> mode_d == MODE_IDLE) else $error("done without return to idle");
  a_arm_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.operation == OP_ARM |=> mode_q == $past(item_i.arm_mode))
    else $error("arm did not load mode");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for frequency_period_duty_meter: directed table, a full window
// at the reset gate length, then random measurement sequences under several gate lengths.
// Depends on fpdm_pkg and the frequency_period_duty_meter RTL.
module tb;
  import fpdm_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned GATE_PHASES  = 7;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct {
    mode_e             mode;
    logic [1:0]        idx;
    logic [TS_W-1:0]   first;
    logic [CNT_W-1:0]  edges;
    logic [GATE_W-1:0] ticks;
    logic [TS_W-1:0]   period;
    logic [TS_W-1:0]   high;
  } meter_t;

  typedef struct {
    op_e             op;
    logic [TS_W-1:0] ts;
    logic [1:0]      am;
    bit              typed;
    out_item_t       want;
  } plan_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  in_item_t          in_data_i   = '0;
  logic              out_stall_i = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [GATE_W-1:0] cfg_wdata_i = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  out_item_t         out_data_o;

  meter_t            meter    = '{MODE_IDLE, IDX_FIRST, '0, '0, '0, '0, '0};
  logic [GATE_W-1:0] gate_len = GATE_RESET;
  out_item_t         readings_due [$];
  int unsigned       beats_taken  = 0;
  int unsigned       failures     = 0;
  int unsigned       cycle_count  = 0;
  bit                quiet        = 1'b0;
  bit                hold_req     = 1'b0;

  frequency_period_duty_meter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("frequency_period_duty_meter: mismatch");
      $finish;
    end
  end

  function automatic out_item_t predict_reading(in_item_t beat);
    out_item_t r;
    r = '0;
    case (op_e'(beat.operation))
      OP_EDGE: begin
        case (meter.mode)
          MODE_COUNT: meter.edges = meter.edges + 1'b1;
          MODE_PERIOD: begin
            if (meter.idx == IDX_FIRST) begin
              meter.first = beat.timestamp;
              meter.idx   = IDX_SECOND;
            end else begin
              meter.period = beat.timestamp - meter.first;
              meter.mode   = MODE_IDLE;
              meter.idx    = IDX_FIRST;
              r.done_res   = 1'b1;
            end
          end
          MODE_DUTY: begin
            if (meter.idx == IDX_FIRST) begin
              meter.first = beat.timestamp;
              meter.idx   = IDX_SECOND;
            end else if (meter.idx == IDX_SECOND) begin
              meter.high = beat.timestamp - meter.first;
              meter.idx  = IDX_THIRD;
            end else begin
              meter.period = beat.timestamp - meter.first;
              meter.mode   = MODE_IDLE;
              meter.idx    = IDX_FIRST;
              r.done_res   = 1'b1;
            end
          end
          default: meter.idx = IDX_FIRST;
        endcase
      end
      OP_TICK: begin
        if (meter.mode == MODE_COUNT) begin
          meter.ticks = meter.ticks + 1'b1;
          if (meter.ticks >= gate_len) begin
            meter.mode  = MODE_IDLE;
            meter.ticks = '0;
            r.done_res  = 1'b1;
          end
        end
      end
      OP_ARM: begin
        meter.mode  = mode_e'(beat.arm_mode);
        meter.idx   = IDX_FIRST;
        meter.edges = '0;
        meter.ticks = '0;
      end
      default: ;
    endcase
    r.mode_now      = meter.mode;
    r.edges_counted = meter.edges;
    r.period_time   = meter.period;
    r.high_time     = meter.high;
    return r;
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    logic [15:0] hi;
    hi = 16'($urandom_range(0, 16'hFFFF));
    return {hi, $urandom()};
  endfunction

  function automatic logic [TS_W-1:0] next_ts(logic [TS_W-1:0] ts);
    case ($urandom_range(0, 3))
      0: return ts + $urandom_range(0, 15);
      1: return ts + $urandom();
      2: return ts + rand_ts();
      default: return rand_ts();
    endcase
  endfunction

  function automatic logic [1:0] rand_am();
    return 2'($urandom_range(0, 3));
  endfunction

  // one input beat; leaves valid high on return, caller lowers it when idle
  task automatic send_beat(op_e op, logic [TS_W-1:0] ts, logic [1:0] am, bit typed,
                           out_item_t want);
    in_item_t  beat;
    out_item_t model;
    int        gap;
    beat.operation = op;
    beat.timestamp = ts;
    beat.arm_mode  = am;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    model = predict_reading(beat);
    readings_due.push_back(typed ? want : model);
    beats_taken++;
    @(negedge clk_i);
  endtask

  task automatic put(op_e op, logic [TS_W-1:0] ts, logic [1:0] am);
    send_beat(op, ts, am, 1'b0, '0);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 7) == 0)
      put($urandom_range(0, 1) ? OP_TICK : OP_NOP, rand_ts(), rand_am());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_gate(logic [GATE_W-1:0] len);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gate_len = len;
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned     stop;
    int unsigned     kind;
    int unsigned     n;
    int unsigned     k;
    logic [TS_W-1:0] ts;
    stop = beats_taken + items;
    while (beats_taken < stop) begin
      kind = $urandom_range(0, 99);
      ts   = rand_ts();
      if (kind < 30) begin
        put(OP_ARM, rand_ts(), MODE_PERIOD);
        repeat (2) begin
          maybe_noise();
          ts = next_ts(ts);
          put(OP_EDGE, ts, rand_am());
        end
      end else if (kind < 55) begin
        put(OP_ARM, rand_ts(), MODE_DUTY);
        repeat (3) begin
          maybe_noise();
          ts = next_ts(ts);
          put(OP_EDGE, ts, rand_am());
        end
      end else if (kind < 75) begin
        put(OP_ARM, rand_ts(), MODE_COUNT);
        n = (gate_len <= 8) ? gate_len + 1 : $urandom_range(0, 6);
        k = $urandom_range(0, 8);
        while (n + k > 0) begin
          if (k == 0 || (n > 0 && $urandom_range(0, 1) == 1)) begin
            put(OP_TICK, rand_ts(), rand_am());
            n--;
          end else begin
            put(OP_EDGE, rand_ts(), rand_am());
            k--;
          end
        end
      end else if (kind < 88) begin
        // broken sequence: partial capture, then restart or abort
        put(OP_ARM, rand_ts(), rand_am());
        repeat ($urandom_range(0, 2)) begin
          ts = next_ts(ts);
          put(OP_EDGE, ts, rand_am());
        end
        if ($urandom_range(0, 1) == 1)
          put(OP_ARM, rand_ts(), MODE_IDLE);
      end else begin
        put(op_e'($urandom_range(0, 3)), rand_ts(), rand_am());
      end
    end
  endtask

  task automatic check_reading(out_item_t got);
    out_item_t exp;
    if (readings_due.size() == 0) begin
      $error("result beat with no reading expected");
      failures++;
      return;
    end
    exp = readings_due.pop_front();
    if (got.mode_now !== exp.mode_now) begin
      $error("mode_now: expected %0d, actual %0d", exp.mode_now, got.mode_now);
      failures++;
    end
    if (got.done_res !== exp.done_res) begin
      $error("done_res: expected %0d, actual %0d", exp.done_res, got.done_res);
      failures++;
    end
    if (got.edges_counted !== exp.edges_counted) begin
      $error("edges_counted: expected %0d, actual %0d", exp.edges_counted, got.edges_counted);
      failures++;
    end
    if (got.period_time !== exp.period_time) begin
      $error("period_time: expected %0h, actual %0h", exp.period_time, got.period_time);
      failures++;
    end
    if (got.high_time !== exp.high_time) begin
      $error("high_time: expected %0h, actual %0h", exp.high_time, got.high_time);
      failures++;
    end
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_reading(out_data_o);
    end
  end

  initial begin : stimulus
    plan_row_t         plan [25];
    logic [GATE_W-1:0] gate_plan [GATE_PHASES];
    int unsigned       i;
    int unsigned       share;
    plan = '{
      '{OP_NOP,  48'hFFFF_FFFF_FFFF, MODE_DUTY,   1'b1,
        '{MODE_IDLE, 1'b0, 32'd0, 48'd0, 48'd0}},
      '{OP_EDGE, 48'h0,              MODE_IDLE,   1'b1,
        '{MODE_IDLE, 1'b0, 32'd0, 48'd0, 48'd0}},
      '{OP_TICK, 48'hFFFF_FFFF_FFFF, MODE_DUTY,   1'b1,
        '{MODE_IDLE, 1'b0, 32'd0, 48'd0, 48'd0}},
      '{OP_ARM,  48'h0,              MODE_PERIOD, 1'b1,
        '{MODE_PERIOD, 1'b0, 32'd0, 48'd0, 48'd0}},
      '{OP_TICK, 48'h0,              MODE_COUNT,  1'b1,
        '{MODE_PERIOD, 1'b0, 32'd0, 48'd0, 48'd0}},
      '{OP_EDGE, 48'hFFFF_FFFF_FFF0, MODE_IDLE,   1'b1,
        '{MODE_PERIOD, 1'b0, 32'd0, 48'd0, 48'd0}},
      '{OP_EDGE, 48'h10,             MODE_IDLE,   1'b1,
        '{MODE_IDLE, 1'b1, 32'd0, 48'h20, 48'd0}},
      '{OP_ARM,  48'h0,              MODE_DUTY,   1'b1,
        '{MODE_DUTY, 1'b0, 32'd0, 48'h20, 48'd0}},
      '{OP_EDGE, 48'h0,              MODE_IDLE,   1'b1,
        '{MODE_DUTY, 1'b0, 32'd0, 48'h20, 48'd0}},
      '{OP_EDGE, 48'hFFFF_FFFF_FFFF, MODE_IDLE,   1'b1,
        '{MODE_DUTY, 1'b0, 32'd0, 48'h20, 48'hFFFF_FFFF_FFFF}},
      '{OP_EDGE, 48'h0,              MODE_IDLE,   1'b1,
        '{MODE_IDLE, 1'b1, 32'd0, 48'd0, 48'hFFFF_FFFF_FFFF}},
      '{OP_ARM,  48'h0,              MODE_PERIOD, 1'b0, '0},
      '{OP_EDGE, 48'h5,              MODE_IDLE,   1'b0, '0},
      '{OP_ARM,  48'h0,              MODE_DUTY,   1'b0, '0},
      '{OP_EDGE, 48'h64,             MODE_IDLE,   1'b0, '0},
      '{OP_ARM,  48'h0,              MODE_IDLE,   1'b0, '0},
      '{OP_EDGE, 48'h7,              MODE_IDLE,   1'b0, '0},
      '{OP_ARM,  48'h0,              MODE_COUNT,  1'b0, '0},
      '{OP_EDGE, 48'hA5A5_5A5A_A5A5, MODE_IDLE,   1'b0, '0},
      '{OP_EDGE, 48'h5A5A_A5A5_5A5A, MODE_DUTY,   1'b0, '0},
      '{OP_TICK, 48'h0,              MODE_IDLE,   1'b0, '0},
      '{OP_NOP,  48'h0,              MODE_IDLE,   1'b0, '0},
      '{OP_ARM,  48'h0,              MODE_COUNT,  1'b0, '0},
      '{OP_EDGE, 48'h1,              MODE_IDLE,   1'b0, '0},
      '{OP_ARM,  48'hFFFF_FFFF_FFFF, MODE_IDLE,   1'b0, '0}
    };
    gate_plan = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd7, 16'd5};
    gate_plan[5] = GATE_W'($urandom_range(4, 12));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < 25; i++)
      send_beat(plan[i].op, plan[i].ts, plan[i].am, plan[i].typed, plan[i].want);

    // full window at the reset gate length
    put(OP_ARM, rand_ts(), MODE_COUNT);
    quiet = 1'b1;
    for (i = 0; i < GATE_RESET; i++) begin
      if ($urandom_range(0, 7) == 0)
        put(OP_EDGE, rand_ts(), rand_am());
      put(OP_TICK, rand_ts(), rand_am());
    end
    quiet = 1'b0;

    for (i = 0; i < GATE_PHASES; i++) begin
      write_gate(gate_plan[i]);
      if (i == 2) begin
        // sink holds off while source keeps going: buffer fills, input stalls
        quiet    = 1'b1;
        hold_req = 1'b1;
        run_phase(40);
        quiet    = 1'b0;
      end else if (i == 5) begin
        quiet = 1'b1;
        run_phase(100);
        quiet = 1'b0;
      end
      // spread what is left of the item budget over the remaining phases
      share = (beats_taken < ITEM_TARGET) ?
              (ITEM_TARGET - beats_taken) / (GATE_PHASES - i) : 1;
      run_phase(share);
    end

    settle();
    if (failures == 0)
      $display("frequency_period_duty_meter: match");
    else
      $display("frequency_period_duty_meter: mismatch");
    $finish;
  end

endmodule

>>> frequency_period_duty_meter.f
design/fpdm_pkg.sv
design/fpdm_core.sv
design/frequency_period_duty_meter.sv
tb/tb.sv
